/* src/sgpm_pkg.sv */
package sgpm_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int MAG_BITS      = SAMPLE_BITS - 1;
    localparam int GAIN_BITS     = 18;
    localparam int PAN_BITS      = 16;
    localparam int FAC_BITS      = 16;
    localparam int GF_BITS       = GAIN_BITS + FAC_BITS;
    localparam int ACC_BITS      = SAMPLE_BITS + 5;
    localparam int MODE_BITS     = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 18;
    localparam int CNT_BITS      = 4;
    localparam int COEF_BITS     = 16;

    // gain times pan factor: 4-bit digits of the factor, msb first
    localparam int GF_DIGIT   = 4;
    localparam int GF_STEPS   = FAC_BITS / GF_DIGIT;
    // sample times gain-factor: 3-bit digits, lsb first, 30 bits shifted out
    localparam int MUL_DIGIT  = 3;
    localparam int MUL_SHIFTS = 30 / MUL_DIGIT;
    // meter smoothing: 4-bit digits of the coefficient, lsb first
    localparam int MTR_DIGIT  = 4;
    localparam int MTR_STEPS  = COEF_BITS / MTR_DIGIT;

    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_LEFT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_RIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAN        = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE       = 2'd3;

    localparam logic [MODE_BITS-1:0] MODE_PASS  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_SWAP  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_LEFT  = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_RIGHT = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_MUTE  = 3'd4;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 18'd65536;
    localparam logic signed [PAN_BITS-1:0] PAN_ONE = 16'sd16384;

    localparam logic [COEF_BITS-1:0] ATTACK_Q16 = 16'd39322;
    localparam logic [COEF_BITS-1:0] DECAY_Q16  = 16'd6554;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] ACC_SMAX = ACC_BITS'(S_MAX);
    localparam logic signed [ACC_BITS-1:0] ACC_SMIN = ACC_BITS'(S_MIN);

    typedef struct packed {
        logic smp_load;
        logic gf_load;
        logic gf_step;
        logic mul_load;
        logic mul_step;
        logic mul_final;
    } gain_ctl_t;

    typedef struct packed {
        logic peak_upd;
        logic load;
        logic step;
        logic commit;
    } meter_ctl_t;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_acc(
        input logic signed [ACC_BITS-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > ACC_SMAX)
        begin
            r = S_MAX;
        end
        else if (v < ACC_SMIN)
        begin
            r = S_MIN;
        end
        else
        begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

/* src/sgpm_gain_lane.sv */
module sgpm_gain_lane
    import sgpm_pkg::*;
(
    input  logic                          clk,
    input  gain_ctl_t                     ctl,
    input  logic [GAIN_BITS-1:0]          gain,
    input  logic [FAC_BITS-1:0]           factor,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] result
);

    logic signed [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic [GF_BITS-1:0]            gf_reg, gf_next;
    logic [FAC_BITS-1:0]           fsh_reg, fsh_next;
    logic [GF_BITS-1:0]            msh_reg, msh_next;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;

    logic [GAIN_BITS+GF_DIGIT-1:0] gpart;
    logic [MUL_DIGIT:0]            dsel;
    logic signed [ACC_BITS-1:0]    spart;
    logic signed [ACC_BITS:0]      sum;

    // gain times one factor digit, msb first
    assign gpart = gain * fsh_reg[FAC_BITS-1 -: GF_DIGIT];

    // the last pass adds the remaining top digit without a shift
    assign dsel  = ctl.mul_final ? msh_reg[MUL_DIGIT:0] : {1'b0, msh_reg[MUL_DIGIT-1:0]};
    assign spart = smp_reg * $signed({1'b0, dsel});
    assign sum   = {acc_reg[ACC_BITS-1], acc_reg} + {spart[ACC_BITS-1], spart};

    always_comb
    begin
        smp_next = smp_reg;
        gf_next  = gf_reg;
        fsh_next = fsh_reg;
        msh_next = msh_reg;
        acc_next = acc_reg;
        if (ctl.smp_load)
        begin
            smp_next = sample;
        end
        if (ctl.gf_load)
        begin
            gf_next  = '0;
            fsh_next = factor;
        end
        else if (ctl.gf_step)
        begin
            gf_next  = (gf_reg << GF_DIGIT) + GF_BITS'(gpart);
            fsh_next = fsh_reg << GF_DIGIT;
        end
        if (ctl.mul_load)
        begin
            msh_next = gf_reg;
            acc_next = '0;
        end
        else if (ctl.mul_step)
        begin
            // arithmetic shift keeps the running floor exact
            acc_next = ACC_BITS'(sum >>> MUL_DIGIT);
            msh_next = msh_reg >> MUL_DIGIT;
        end
        else if (ctl.mul_final)
        begin
            acc_next = sum[ACC_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
        gf_reg  <= gf_next;
        fsh_reg <= fsh_next;
        msh_reg <= msh_next;
        acc_reg <= acc_next;
    end

    assign result = sat_acc(acc_reg);

endmodule

/* src/sgpm_meter_lane.sv */
module sgpm_meter_lane
    import sgpm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  meter_ctl_t                    ctl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic [MAG_BITS-1:0]           meter
);

    logic [MAG_BITS-1:0]           peak_reg, peak_next;
    logic [MAG_BITS-1:0]           prev_reg, prev_next;
    logic signed [SAMPLE_BITS-1:0] diff_reg, diff_next;
    logic [COEF_BITS-1:0]          xsh_reg, xsh_next;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;

    logic signed [SAMPLE_BITS-1:0] negv;
    logic [MAG_BITS-1:0]           mag;
    logic signed [ACC_BITS-1:0]    mpart;
    logic signed [ACC_BITS:0]      sum;

    assign negv = -sample;

    // most negative sample clamps to the largest positive magnitude
    always_comb
    begin
        if (!sample[SAMPLE_BITS-1])
        begin
            mag = sample[MAG_BITS-1:0];
        end
        else if (sample == S_MIN)
        begin
            mag = {MAG_BITS{1'b1}};
        end
        else
        begin
            mag = negv[MAG_BITS-1:0];
        end
    end

    assign mpart = diff_reg * $signed({1'b0, xsh_reg[MTR_DIGIT-1:0]});
    assign sum   = {acc_reg[ACC_BITS-1], acc_reg} + {mpart[ACC_BITS-1], mpart};

    always_comb
    begin
        peak_next = peak_reg;
        prev_next = prev_reg;
        diff_next = diff_reg;
        xsh_next  = xsh_reg;
        acc_next  = acc_reg;
        if (ctl.peak_upd && (mag > peak_reg))
        begin
            peak_next = mag;
        end
        if (ctl.load)
        begin
            diff_next = $signed({1'b0, peak_reg}) - $signed({1'b0, prev_reg});
            xsh_next  = (peak_reg < prev_reg) ? DECAY_Q16 : ATTACK_Q16;
            acc_next  = '0;
        end
        else if (ctl.step)
        begin
            acc_next = ACC_BITS'(sum >>> MTR_DIGIT);
            xsh_next = xsh_reg >> MTR_DIGIT;
        end
        if (ctl.commit)
        begin
            // new level stays between prev and peak, so modulo width is exact
            prev_next = prev_reg + acc_reg[MAG_BITS-1:0];
            peak_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
            prev_reg <= '0;
        end
        else
        begin
            peak_reg <= peak_next;
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        xsh_reg  <= xsh_next;
        acc_reg  <= acc_next;
    end

    assign meter = prev_reg;

endmodule

/* src/stereo_gain_pan_meter_unit.sv */
// channel   handshake              payload
// cfg       cfg_wr_en              cfg_index, cfg_data
// input     in_valid / in_ready    left_in, right_in, end_of_block
// output    out_valid / out_ready  left_out, right_out, meter_left, meter_right, meter_valid
//
// one transaction at a time: the next input is accepted only once the current item is through
// every item runs the 3-bit digit-serial sample multiplier; end_of_block adds the meter
// smoothing, and the first item after a config write adds the gain-pan product
// reset clears config to defaults and meter state to zero
// a finished result waits in the output register; the next input is accepted meanwhile
// and held in the last stage only if the previous result is still not taken
module stereo_gain_pan_meter_unit
    import sgpm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    input  logic                          end_of_block,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    output logic [MAG_BITS-1:0]           meter_left,
    output logic [MAG_BITS-1:0]           meter_right,
    output logic                          meter_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GF    = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ROUTE = 3'd3;
    localparam logic [2:0] S_METER = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [CNT_BITS-1:0] GF_LAST  = CNT_BITS'(GF_STEPS);
    localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(MUL_SHIFTS + 1);
    localparam logic [CNT_BITS-1:0] MTR_LAST = CNT_BITS'(MTR_STEPS + 1);

    logic [2:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                dirty_reg, dirty_next;
    logic                eob_reg, eob_next;

    logic [GAIN_BITS-1:0]        gain_l_reg, gain_l_next;
    logic [GAIN_BITS-1:0]        gain_r_reg, gain_r_next;
    logic signed [PAN_BITS-1:0]  pan_reg, pan_next;
    logic [MODE_BITS-1:0]        mode_reg, mode_next;

    logic signed [SAMPLE_BITS-1:0] ol_reg, ol_next;
    logic signed [SAMPLE_BITS-1:0] or_reg, or_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] left_out_reg, left_out_next;
    logic signed [SAMPLE_BITS-1:0] right_out_reg, right_out_next;
    logic [MAG_BITS-1:0]           meter_l_reg, meter_l_next;
    logic [MAG_BITS-1:0]           meter_r_reg, meter_r_next;
    logic                          meter_valid_reg, meter_valid_next;

    logic signed [PAN_BITS-1:0]    pan_c;
    logic signed [PAN_BITS:0]      fac_l_w, fac_r_w;
    logic [FAC_BITS-1:0]           fac_l, fac_r;
    logic signed [SAMPLE_BITS-1:0] res_l, res_r;
    logic signed [SAMPLE_BITS:0]   lr_sum;
    logic signed [SAMPLE_BITS-1:0] lr_sat;
    logic signed [SAMPLE_BITS-1:0] rt_l, rt_r;
    logic [MAG_BITS-1:0]           mtr_l, mtr_r;
    logic                          accept;
    logic                          out_free;

    gain_ctl_t  gctl;
    meter_ctl_t mctl;

    // pan clamped to plus or minus one, factors 1 - pan and 1 + pan in 0..2.0
    always_comb
    begin
        if (pan_reg > PAN_ONE)
        begin
            pan_c = PAN_ONE;
        end
        else if (pan_reg < -PAN_ONE)
        begin
            pan_c = -PAN_ONE;
        end
        else
        begin
            pan_c = pan_reg;
        end
    end

    assign fac_l_w = {PAN_ONE[PAN_BITS-1], PAN_ONE} - {pan_c[PAN_BITS-1], pan_c};
    assign fac_r_w = {PAN_ONE[PAN_BITS-1], PAN_ONE} + {pan_c[PAN_BITS-1], pan_c};
    assign fac_l   = fac_l_w[FAC_BITS-1:0];
    assign fac_r   = fac_r_w[FAC_BITS-1:0];

    sgpm_gain_lane u_gain_l (
        .clk    (clk),
        .ctl    (gctl),
        .gain   (gain_l_reg),
        .factor (fac_l),
        .sample (left_in),
        .result (res_l)
    );

    sgpm_gain_lane u_gain_r (
        .clk    (clk),
        .ctl    (gctl),
        .gain   (gain_r_reg),
        .factor (fac_r),
        .sample (right_in),
        .result (res_r)
    );

    // channel routing
    assign lr_sum = {res_l[SAMPLE_BITS-1], res_l} + {res_r[SAMPLE_BITS-1], res_r};
    assign lr_sat = sat_acc(ACC_BITS'(lr_sum));

    always_comb
    begin
        unique case (mode_reg)
            MODE_SWAP:
            begin
                rt_l = res_r;
                rt_r = res_l;
            end
            MODE_LEFT:
            begin
                rt_l = lr_sat;
                rt_r = '0;
            end
            MODE_RIGHT:
            begin
                rt_l = '0;
                rt_r = lr_sat;
            end
            MODE_MUTE:
            begin
                rt_l = '0;
                rt_r = '0;
            end
            default:
            begin
                rt_l = res_l;
                rt_r = res_r;
            end
        endcase
    end

    sgpm_meter_lane u_meter_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mctl),
        .sample (rt_l),
        .meter  (mtr_l)
    );

    sgpm_meter_lane u_meter_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mctl),
        .sample (rt_r),
        .meter  (mtr_r)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // configuration
    always_comb
    begin
        gain_l_next = gain_l_reg;
        gain_r_next = gain_r_reg;
        pan_next    = pan_reg;
        mode_next   = mode_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GAIN_LEFT:  gain_l_next = cfg_data;
                REG_GAIN_RIGHT: gain_r_next = cfg_data;
                REG_PAN:        pan_next    = cfg_data[PAN_BITS-1:0];
                REG_MODE:       mode_next   = cfg_data[MODE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        dirty_next       = dirty_reg;
        eob_next         = eob_reg;
        ol_next          = ol_reg;
        or_next          = or_reg;
        out_valid_next   = out_valid_reg;
        left_out_next    = left_out_reg;
        right_out_next   = right_out_reg;
        meter_l_next     = meter_l_reg;
        meter_r_next     = meter_r_reg;
        meter_valid_next = meter_valid_reg;
        gctl             = '0;
        mctl             = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    gctl.smp_load = 1'b1;
                    eob_next      = end_of_block;
                    cnt_next      = '0;
                    // gain-pan product is redone only after reset or a config write
                    state_next    = dirty_reg ? S_GF : S_MUL;
                end
            end
            S_GF:
            begin
                gctl.gf_load = (cnt_reg == '0);
                gctl.gf_step = (cnt_reg != '0);
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == GF_LAST)
                begin
                    dirty_next = 1'b0;
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                gctl.mul_load  = (cnt_reg == '0);
                gctl.mul_final = (cnt_reg == MUL_LAST);
                gctl.mul_step  = (cnt_reg != '0) && (cnt_reg != MUL_LAST);
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_ROUTE;
                end
            end
            S_ROUTE:
            begin
                mctl.peak_upd = 1'b1;
                ol_next       = rt_l;
                or_next       = rt_r;
                state_next    = eob_reg ? S_METER : S_DONE;
            end
            S_METER:
            begin
                mctl.load   = (cnt_reg == '0);
                mctl.commit = (cnt_reg == MTR_LAST);
                mctl.step   = (cnt_reg != '0) && (cnt_reg != MTR_LAST);
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == MTR_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    left_out_next    = ol_reg;
                    right_out_next   = or_reg;
                    meter_valid_next = eob_reg;
                    meter_l_next     = eob_reg ? mtr_l : '0;
                    meter_r_next     = eob_reg ? mtr_r : '0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            dirty_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            dirty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            gain_l_reg    <= GAIN_RESET;
            gain_r_reg    <= GAIN_RESET;
            pan_reg       <= '0;
            mode_reg      <= MODE_PASS;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
            gain_l_reg    <= gain_l_next;
            gain_r_reg    <= gain_r_next;
            pan_reg       <= pan_next;
            mode_reg      <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eob_reg         <= eob_next;
        ol_reg          <= ol_next;
        or_reg          <= or_next;
        left_out_reg    <= left_out_next;
        right_out_reg   <= right_out_next;
        meter_l_reg     <= meter_l_next;
        meter_r_reg     <= meter_r_next;
        meter_valid_reg <= meter_valid_next;
    end

    assign out_valid   = out_valid_reg;
    assign left_out    = left_out_reg;
    assign right_out   = right_out_reg;
    assign meter_left  = meter_l_reg;
    assign meter_right = meter_r_reg;
    assign meter_valid = meter_valid_reg;

    // one transaction in flight: no accept right after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // meter fields are zero on results without a block end
    a_meter_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !meter_valid) |-> (meter_left == '0 && meter_right == '0))
        else $error("meter fields set without meter_valid");

    // gain-pan recompute only runs after reset or when config changed
    a_gf_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GF) |-> dirty_reg)
        else $error("gain-pan product recomputed without a config write");

    // a finished item waits while the output register is still occupied
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid && !out_ready) |=> (state_reg == S_DONE))
        else $error("result dropped while output was stalled");

endmodule
